/* hdl/speed_pi_ramp_motor_mixer_unit_macros.svh */
// Assertion macros for the speed loop and motor mixer unit.
// Included by the top level; depends on nothing else.
`ifndef SPEED_PI_RAMP_MOTOR_MIXER_UNIT_MACROS_SVH
`define SPEED_PI_RAMP_MOTOR_MIXER_UNIT_MACROS_SVH

// A property that must hold on every clock edge out of reset.
`define SPRM_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define SPRM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define SPRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sprm_pkg.sv */
// Constants shared by the speed loop and motor mixer unit.
// Depends on nothing; used by speed_pi_ramp_motor_mixer_unit.
`default_nettype none

package sprm_pkg;

   // Item kinds carried on req_tuser.
   localparam logic CmdPeriod = 1'b0;
   localparam logic CmdTick   = 1'b1;

   // Register indexes on the configuration port.
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 17;
   localparam logic [CsrAddrW-1:0] CsrPropGain    = 3'd0;
   localparam logic [CsrAddrW-1:0] CsrIntegGain   = 3'd1;
   localparam logic [CsrAddrW-1:0] CsrDerivGain   = 3'd2;
   localparam logic [CsrAddrW-1:0] CsrDeadZone    = 3'd3;
   localparam logic [CsrAddrW-1:0] CsrSpeedEnable = 3'd4;
   localparam logic [CsrAddrW-1:0] CsrSteerEnable = 3'd5;
   localparam logic [CsrAddrW-1:0] CsrRunEnable   = 3'd6;

   // Field and register widths.
   localparam int GainW    = 10;
   localparam int DerivW   = 17;
   localparam int ErrW     = 16;
   localparam int TermW    = 16;
   localparam int StepW    = 5;
   localparam int OutW     = 24;
   localparam int DutyW    = 10;
   localparam int DriveW   = 19;
   localparam int IntegW   = 13;
   localparam int ReqDataW = 56;
   localparam int RspDataW = 64;
   localparam int RspPadW  = RspDataW - OutW - 2 * DutyW - DriveW;

   // Widths of the mixing arithmetic; MixW and MixMagW are in hundredths of a count.
   localparam int MixW      = 26;
   localparam int MixMagW   = 24;
   localparam int DriveMagW = 18;

   // Reset values of the registers.
   localparam logic [GainW-1:0]  PropGainReset  = 10'd58;
   localparam logic [GainW-1:0]  IntegGainReset = 10'd0;
   localparam logic [DerivW-1:0] DerivGainReset = 17'd0;
   localparam logic [DutyW-1:0]  DeadZoneReset  = 10'd0;

   // Limits.
   localparam logic signed [ErrW-1:0] ErrClamp = 16'sd800;
   localparam logic [IntegW-1:0]      IntegMax = 13'd5000;
   localparam logic [DutyW-1:0]       DutyMax  = 10'd980;
   localparam logic [OutW-1:0]        OutMax   = 24'h7F_FFFF;
   localparam logic [OutW-1:0]        OutMin   = 24'h80_0000;

   // Exact division by 100 of a magnitude below 2^24: (x * mul) >> shift.
   localparam int Div100MulW = 25;
   localparam int Div100Shift = 31;
   localparam logic [Div100MulW-1:0] Div100Mul = 25'd21474837;

endpackage

`default_nettype wire

/* hdl/speed_pi_ramp_motor_mixer_unit.sv */
// Speed loop with ramped output and left H-bridge mixer, top level.
// Depends on sprm_pkg and speed_pi_ramp_motor_mixer_unit_macros.svh.
//
//   Channel  Ports                   Moves
//   req      req_tvalid/tready       one input word, kind on req_tuser
//   rsp      rsp_tvalid/tready       one result word per input word
//   csr      csr_wen/addr/wdata      one register write per cycle
//
// One word is accepted per cycle unless a held result stalls the pipe.
// Four register stages: input, PID and ramp product, ramp quotient and
// mixing, divide by 100 with dead zone into the result register.
// The speed loop state is read and written in the PID and ramp product stage only.
// Each stage moves on when the one after it is empty or moving, so a
// held result stalls the pipe only once every stage is full.
// Reset is synchronous; it clears valid flags and loop state, loads config defaults.
`default_nettype none

`include "speed_pi_ramp_motor_mixer_unit_macros.svh"

module speed_pi_ramp_motor_mixer_unit #(
   parameter int RAMP_STEPS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // speed_error[15:0], balance_term[31:16], steer_term[47:32], sub_step[52:48]
   input  logic [sprm_pkg::ReqDataW-1:0]   req_tdata,
   // command
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // speed_out[23:0], left_fwd_duty[33:24], left_rev_duty[43:34], right_drive[62:44]
   output logic [sprm_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                            csr_wen,
   input  logic [sprm_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [sprm_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int RampCmpW = ($clog2(RAMP_STEPS + 1) > sprm_pkg::StepW) ?
                             $clog2(RAMP_STEPS + 1) : sprm_pkg::StepW;
   localparam logic [RampCmpW-1:0] RampLimit = RampCmpW'(RAMP_STEPS);
   localparam int RampMagW  = sprm_pkg::OutW + sprm_pkg::StepW;
   localparam int RampShift = RampMagW + $clog2(RAMP_STEPS);
   localparam int RampMulW  = RampMagW + 1;
   localparam int RampProdW = RampMagW + RampMulW;
   localparam longint unsigned RampMulVal =
      ((64'd1 << RampShift) + RAMP_STEPS - 1) / RAMP_STEPS;
   localparam logic [RampMulW-1:0] RampMul = RampMulW'(RampMulVal);

   // Configuration registers.
   logic [sprm_pkg::GainW-1:0]  prop_gain_ff;
   logic [sprm_pkg::GainW-1:0]  integ_gain_ff;
   logic [sprm_pkg::DerivW-1:0] deriv_gain_ff;
   logic [sprm_pkg::DutyW-1:0]  dead_zone_ff;
   logic                        speed_enable_ff;
   logic                        steer_enable_ff;
   logic                        run_enable_ff;

   // Loop state.
   logic [sprm_pkg::IntegW-1:0]      integ_ff;
   logic signed [sprm_pkg::OutW-1:0] out_old_ff;
   logic signed [sprm_pkg::OutW-1:0] out_new_ff;
   logic signed [sprm_pkg::ErrW-1:0] err_last_ff;

   // Stage 0: input register.
   logic                              s0_valid_ff;
   logic                              s0_cmd_ff;
   logic signed [sprm_pkg::ErrW-1:0]  s0_err_ff;
   logic signed [sprm_pkg::TermW-1:0] s0_bal_ff;
   logic signed [sprm_pkg::TermW-1:0] s0_steer_ff;
   logic [sprm_pkg::StepW-1:0]        s0_step_ff;

   // Stage 1: PID result or ramp product.
   logic                              s1_valid_ff;
   logic                              s1_cmd_ff;
   logic signed [sprm_pkg::OutW-1:0]  s1_speed_ff;
   logic [RampMagW-1:0]               s1_prod_ff;
   logic                              s1_neg_ff;
   logic signed [sprm_pkg::OutW-1:0]  s1_old_ff;
   logic signed [sprm_pkg::TermW-1:0] s1_bal_ff;
   logic signed [sprm_pkg::TermW-1:0] s1_steer_ff;

   // Stage 2: ramped speed and mixed drives in hundredths.
   logic                             s2_valid_ff;
   logic                             s2_cmd_ff;
   logic signed [sprm_pkg::OutW-1:0] s2_speed_ff;
   logic signed [sprm_pkg::MixW-1:0] s2_lh_ff;
   logic signed [sprm_pkg::MixW-1:0] s2_rh_ff;

   // Result register.
   logic                               rsp_valid_ff;
   logic signed [sprm_pkg::OutW-1:0]   rsp_speed_ff;
   logic [sprm_pkg::DutyW-1:0]         rsp_fwd_ff;
   logic [sprm_pkg::DutyW-1:0]         rsp_rev_ff;
   logic signed [sprm_pkg::DriveW-1:0] rsp_right_ff;

   logic s0_rdy, s1_rdy, s2_rdy, s3_rdy;
   logic period_fire;

   // Stage 1 logic.
   logic signed [sprm_pkg::ErrW-1:0] err_clamped;
   logic signed [26:0]               prop_prod;
   logic signed [26:0]               integ_prod;
   logic signed [27:0]               integ_sum;
   logic [sprm_pkg::IntegW-1:0]      integ_in;
   logic signed [sprm_pkg::ErrW:0]   err_diff;
   logic signed [34:0]               deriv_prod;
   logic signed [35:0]               pid_sum;
   logic signed [sprm_pkg::OutW-1:0] pid_sat_in;
   logic signed [sprm_pkg::OutW:0]   ramp_diff;
   logic signed [sprm_pkg::OutW:0]   ramp_abs;
   logic [sprm_pkg::StepW-1:0]       ramp_step;
   logic [RampMagW-1:0]              ramp_prod_in;

   // Stage 2 logic.
   logic [RampProdW-1:0]             ramp_q_prod;
   logic [sprm_pkg::OutW-1:0]        ramp_q;
   logic signed [sprm_pkg::OutW:0]   ramp_sum;
   logic signed [sprm_pkg::OutW-1:0] ramp_val;
   logic signed [sprm_pkg::OutW-1:0] s2_speed_in;
   logic signed [sprm_pkg::MixW-1:0] bal100;
   logic signed [sprm_pkg::MixW-1:0] steer150;
   logic signed [sprm_pkg::MixW-1:0] steer50;
   logic signed [sprm_pkg::MixW-1:0] pwm;
   logic signed [sprm_pkg::MixW-1:0] lh_in;
   logic signed [sprm_pkg::MixW-1:0] rh_in;

   // Stage 3 logic.
   logic [sprm_pkg::MixW-1:0]           lh_abs;
   logic [sprm_pkg::MixW-1:0]           rh_abs;
   logic [sprm_pkg::MixMagW+sprm_pkg::Div100MulW-1:0] lh_prod;
   logic [sprm_pkg::MixMagW+sprm_pkg::Div100MulW-1:0] rh_prod;
   logic [sprm_pkg::DriveMagW-1:0]      left_mag;
   logic [sprm_pkg::DriveMagW-1:0]      right_mag;
   logic [sprm_pkg::DriveW-1:0]         duty_sum;
   logic [sprm_pkg::DutyW-1:0]          duty;
   logic                                left_rev;
   logic signed [sprm_pkg::DriveW-1:0]  right_val;
   logic [sprm_pkg::DutyW-1:0]          fwd_in;
   logic [sprm_pkg::DutyW-1:0]          rev_in;
   logic signed [sprm_pkg::DriveW-1:0]  right_in;

   // Handshake chain.
   assign s3_rdy      = !rsp_valid_ff || rsp_tready;
   assign s2_rdy      = !s2_valid_ff || s3_rdy;
   assign s1_rdy      = !s1_valid_ff || s2_rdy;
   assign s0_rdy      = !s0_valid_ff || s1_rdy;
   assign req_tready  = s0_rdy;
   assign period_fire = s0_valid_ff && s1_rdy && (s0_cmd_ff == sprm_pkg::CmdPeriod);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{sprm_pkg::RspPadW{1'b0}}, rsp_right_ff, rsp_rev_ff,
                        rsp_fwd_ff, rsp_speed_ff};

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= sprm_pkg::PropGainReset;
         integ_gain_ff   <= sprm_pkg::IntegGainReset;
         deriv_gain_ff   <= sprm_pkg::DerivGainReset;
         dead_zone_ff    <= sprm_pkg::DeadZoneReset;
         speed_enable_ff <= 1'b1;
         steer_enable_ff <= 1'b1;
         run_enable_ff   <= 1'b1;
      end else if (csr_wen) begin
         unique case (csr_addr)
            sprm_pkg::CsrPropGain: begin
               prop_gain_ff <= csr_wdata[sprm_pkg::GainW-1:0];
            end
            sprm_pkg::CsrIntegGain: begin
               integ_gain_ff <= csr_wdata[sprm_pkg::GainW-1:0];
            end
            sprm_pkg::CsrDerivGain: begin
               deriv_gain_ff <= csr_wdata[sprm_pkg::DerivW-1:0];
            end
            sprm_pkg::CsrDeadZone: begin
               dead_zone_ff <= csr_wdata[sprm_pkg::DutyW-1:0];
            end
            sprm_pkg::CsrSpeedEnable: begin
               speed_enable_ff <= csr_wdata[0];
            end
            sprm_pkg::CsrSteerEnable: begin
               steer_enable_ff <= csr_wdata[0];
            end
            sprm_pkg::CsrRunEnable: begin
               run_enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage 1: PID update for period words, ramp product for tick words.
   always_comb begin
      err_clamped = (s0_err_ff > sprm_pkg::ErrClamp) ? sprm_pkg::ErrClamp : s0_err_ff;

      integ_prod = $signed({1'b0, integ_gain_ff}) * err_clamped;
      integ_sum  = 28'($signed({1'b0, integ_ff})) + 28'(integ_prod);
      if (integ_sum[27]) begin
         integ_in = '0;
      end else if (integ_sum[26:0] > 27'(sprm_pkg::IntegMax)) begin
         integ_in = sprm_pkg::IntegMax;
      end else begin
         integ_in = integ_sum[sprm_pkg::IntegW-1:0];
      end

      prop_prod  = $signed({1'b0, prop_gain_ff}) * err_clamped;
      err_diff   = 17'(s0_err_ff) - 17'(err_last_ff);
      deriv_prod = $signed({1'b0, deriv_gain_ff}) * err_diff;
      pid_sum    = 36'(prop_prod) + 36'($signed({1'b0, integ_in})) + 36'(deriv_prod);

      if (!pid_sum[35] && (|pid_sum[34:23])) begin
         pid_sat_in = sprm_pkg::OutMax;
      end else if (pid_sum[35] && !(&pid_sum[34:23])) begin
         pid_sat_in = sprm_pkg::OutMin;
      end else begin
         pid_sat_in = pid_sum[sprm_pkg::OutW-1:0];
      end

      ramp_diff = 25'(out_new_ff) - 25'(out_old_ff);
      ramp_abs  = ramp_diff[sprm_pkg::OutW] ? -ramp_diff : ramp_diff;
      if (RampCmpW'(s0_step_ff) > RampLimit) begin
         ramp_step = RampLimit[sprm_pkg::StepW-1:0];
      end else begin
         ramp_step = s0_step_ff;
      end
      ramp_prod_in = RampMagW'(ramp_abs[sprm_pkg::OutW-1:0]) * RampMagW'(ramp_step);
   end

   // Stage 2: ramp quotient, balance and steer mixing.
   always_comb begin
      ramp_q_prod = RampProdW'(s1_prod_ff) * RampProdW'(RampMul);
      ramp_q      = ramp_q_prod[RampShift +: sprm_pkg::OutW];
      ramp_sum    = s1_neg_ff ? (25'(s1_old_ff) - $signed({1'b0, ramp_q}))
                              : (25'(s1_old_ff) + $signed({1'b0, ramp_q}));
      ramp_val    = ramp_sum[sprm_pkg::OutW-1:0];
      s2_speed_in = (s1_cmd_ff == sprm_pkg::CmdTick) ? ramp_val : s1_speed_ff;

      bal100   = 26'(s1_bal_ff) * 26'sd100;
      steer150 = 26'(s1_steer_ff) * 26'sd150;
      steer50  = 26'(s1_steer_ff) * 26'sd50;
      pwm      = speed_enable_ff ? (bal100 - 26'(ramp_val)) : bal100;

      if (!steer_enable_ff) begin
         lh_in = pwm;
         rh_in = pwm;
      end else if (s1_steer_ff[sprm_pkg::TermW-1]) begin
         lh_in = pwm - steer50;
         rh_in = pwm + steer150;
      end else begin
         lh_in = pwm - steer150;
         rh_in = pwm + steer50;
      end
   end

   // Stage 3: divide by 100, enables, dead zone and duty saturation.
   always_comb begin
      lh_abs  = s2_lh_ff[sprm_pkg::MixW-1] ? -s2_lh_ff : s2_lh_ff;
      rh_abs  = s2_rh_ff[sprm_pkg::MixW-1] ? -s2_rh_ff : s2_rh_ff;
      lh_prod = 49'(lh_abs[sprm_pkg::MixMagW-1:0]) * 49'(sprm_pkg::Div100Mul);
      rh_prod = 49'(rh_abs[sprm_pkg::MixMagW-1:0]) * 49'(sprm_pkg::Div100Mul);

      if (run_enable_ff) begin
         left_mag  = lh_prod[sprm_pkg::Div100Shift +: sprm_pkg::DriveMagW];
         right_mag = rh_prod[sprm_pkg::Div100Shift +: sprm_pkg::DriveMagW];
      end else begin
         left_mag  = '0;
         right_mag = '0;
      end

      right_val = s2_rh_ff[sprm_pkg::MixW-1] ? -$signed({1'b0, right_mag})
                                             : $signed({1'b0, right_mag});
      left_rev  = s2_lh_ff[sprm_pkg::MixW-1] && (left_mag != '0);
      duty_sum  = 19'(dead_zone_ff) + 19'(left_mag);
      duty      = (duty_sum > 19'(sprm_pkg::DutyMax)) ? sprm_pkg::DutyMax
                                                      : duty_sum[sprm_pkg::DutyW-1:0];

      if (s2_cmd_ff == sprm_pkg::CmdTick) begin
         fwd_in   = left_rev ? '0 : duty;
         rev_in   = left_rev ? duty : '0;
         right_in = right_val;
      end else begin
         fwd_in   = '0;
         rev_in   = '0;
         right_in = '0;
      end
   end

   // Valid flags and loop state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         out_old_ff   <= '0;
         out_new_ff   <= '0;
         err_last_ff  <= '0;
      end else begin
         if (s0_rdy) begin
            s0_valid_ff <= req_tvalid;
         end
         if (s1_rdy) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_rdy) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_rdy) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (period_fire) begin
            integ_ff    <= integ_in;
            out_old_ff  <= out_new_ff;
            out_new_ff  <= pid_sat_in;
            err_last_ff <= s0_err_ff;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (s0_rdy) begin
         s0_cmd_ff   <= req_tuser;
         s0_err_ff   <= req_tdata[15:0];
         s0_bal_ff   <= req_tdata[31:16];
         s0_steer_ff <= req_tdata[47:32];
         s0_step_ff  <= req_tdata[52:48];
      end
      if (s1_rdy) begin
         s1_cmd_ff   <= s0_cmd_ff;
         s1_speed_ff <= pid_sat_in;
         s1_prod_ff  <= ramp_prod_in;
         s1_neg_ff   <= ramp_diff[sprm_pkg::OutW];
         s1_old_ff   <= out_old_ff;
         s1_bal_ff   <= s0_bal_ff;
         s1_steer_ff <= s0_steer_ff;
      end
      if (s2_rdy) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_speed_ff <= s2_speed_in;
         s2_lh_ff    <= lh_in;
         s2_rh_ff    <= rh_in;
      end
      if (s3_rdy) begin
         rsp_speed_ff <= s2_speed_ff;
         rsp_fwd_ff   <= fwd_in;
         rsp_rev_ff   <= rev_in;
         rsp_right_ff <= right_in;
      end
   end

   `SPRM_ASSERT_ALWAYS(a_integ_bound, clock, reset, integ_ff <= sprm_pkg::IntegMax, "integral above limit")
   `SPRM_ASSERT_IMPLY(a_one_direction, clock, reset, rsp_valid_ff, rsp_fwd_ff == '0 || rsp_rev_ff == '0, "both bridge sides driven")
   `SPRM_ASSERT_IMPLY(a_duty_bound, clock, reset, rsp_valid_ff, rsp_fwd_ff <= sprm_pkg::DutyMax && rsp_rev_ff <= sprm_pkg::DutyMax, "duty above saturation")
   `SPRM_ASSERT_NEXT(a_old_follows_new, clock, reset, period_fire, out_old_ff == $past(out_new_ff), "old speed output not taken from new")

endmodule

`default_nettype wire
